[rtl/cbm_pkg.sv]
// Shared types and constants of the cartridge bank mapper.
package cbm_pkg;

  localparam logic [1:0] REQ_CPU_WRITE = 2'd0;
  localparam logic [1:0] REQ_CPU_XLATE = 2'd1;
  localparam logic [1:0] REQ_PPU_XLATE = 2'd2;

  localparam logic [1:0] TARGET_NONE  = 2'd0;
  localparam logic [1:0] TARGET_PRG   = 2'd1;
  localparam logic [1:0] TARGET_CHR   = 2'd2;
  localparam logic [1:0] TARGET_CIRAM = 2'd3;

  localparam logic [2:0] REGION_SELECT = 3'd4;
  localparam logic [2:0] REGION_DATA   = 3'd5;
  localparam logic [2:0] REGION_MIRROR = 3'd7;

  localparam int         PRG_BANKS = 2;
  localparam int         CHR_BANKS = 6;
  localparam logic [6:0] LAST_PRG_RESET = 7'd127;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] addr;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] rom_addr;
    logic        ciram_a10;
  } result_t;

  typedef struct packed {
    logic [PRG_BANKS-1:0][7:0] prg;
    logic [CHR_BANKS-1:0][7:0] chr;
    logic                      hmirror;
    logic [6:0]                last_prg;
  } bank_state_t;

endpackage

[rtl/cartridge_bank_mapper.sv]
// Top level of the cartridge bank mapper.
// An accepted item is first registered, then translated combinationally, and its
// result is registered and strobed on done.
// Throughput is one item per cycle; busy stays low and the receiver cannot stall.
// Synchronous reset clears the pipeline and loads the bank registers with their
// power-on values and the last PRG bank register with 127.
module cartridge_bank_mapper (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cbm_pkg::req_t     req,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_data,
  output logic              done,
  output cbm_pkg::result_t  result
);
  import cbm_pkg::*;

  req_t        req_q;
  logic        req_vld;
  bank_state_t state;
  result_t     res_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      req_vld <= start && !busy;
      done    <= req_vld;
    end
    req_q  <= req;
    result <= res_next;
  end

  cbm_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .req_vld  (req_vld),
    .req      (req_q),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .state    (state)
  );

  cbm_xlate u_xlate (
    .req   (req_q),
    .state (state),
    .res   (res_next)
  );

endmodule

[rtl/cbm_regs.sv]
// Bank, command and mirroring registers, loaded by CPU write items; the last PRG bank register is loaded by cfg_we.
module cbm_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_vld,
  input  cbm_pkg::req_t       req,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_data,
  output cbm_pkg::bank_state_t state
);
  import cbm_pkg::*;

  logic [2:0]                bank_select;
  logic [PRG_BANKS-1:0][7:0] prg_bank;
  logic [CHR_BANKS-1:0][7:0] chr_bank;
  logic                      horizontal_mirror;
  logic [6:0]                last_prg;
  logic                      wr;
  logic [2:0]                chr_sel;

  assign wr      = req_vld && (req.req_type == REQ_CPU_WRITE) && !req.addr[0];
  assign chr_sel = bank_select - 3'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select       <= '0;
      prg_bank[0]       <= 8'd0;
      prg_bank[1]       <= 8'd1;
      chr_bank[0]       <= 8'd0;
      chr_bank[1]       <= 8'd2;
      chr_bank[2]       <= 8'd4;
      chr_bank[3]       <= 8'd5;
      chr_bank[4]       <= 8'd6;
      chr_bank[5]       <= 8'd7;
      horizontal_mirror <= 1'b0;
      last_prg          <= LAST_PRG_RESET;
    end else begin
      if (cfg_we) begin
        last_prg <= cfg_data;
      end
      if (wr) begin
        case (req.addr[15:13])
          REGION_SELECT: bank_select <= req.data[2:0];
          REGION_DATA: begin
            if (bank_select < 3'd2) begin
              prg_bank[bank_select[0]] <= req.data;
            end else begin
              chr_bank[chr_sel] <= req.data;
            end
          end
          REGION_MIRROR: horizontal_mirror <= req.data[0];
          default: ;
        endcase
      end
    end
  end

  assign state.prg      = prg_bank;
  assign state.chr      = chr_bank;
  assign state.hmirror  = horizontal_mirror;
  assign state.last_prg = last_prg;

endmodule

[rtl/cbm_xlate.sv]
// Address translation of CPU and PPU items onto PRG ROM, CHR ROM and CIRAM.
module cbm_xlate (
  input  cbm_pkg::req_t        req,
  input  cbm_pkg::bank_state_t state,
  output cbm_pkg::result_t     res
);
  import cbm_pkg::*;

  logic [13:0] ppu_addr;
  logic [7:0]  chr2k;
  logic [7:0]  chr1k;

  assign ppu_addr = req.addr[13:0];
  assign chr2k    = state.chr[{2'b00, ppu_addr[11]}];
  assign chr1k    = state.chr[3'd2 + {1'b0, ppu_addr[11:10]}];

  always_comb begin
    res = '0;
    case (req.req_type)
      REQ_CPU_XLATE: begin
        if (req.addr[15:14] == 2'b11) begin
          res.target   = TARGET_PRG;
          res.rom_addr = {state.last_prg, req.addr[13:0]};
        end else if (req.addr[15]) begin
          res.target   = TARGET_PRG;
          res.rom_addr = {state.prg[req.addr[13]], req.addr[12:0]};
        end
      end
      REQ_PPU_XLATE: begin
        if (ppu_addr[13]) begin
          res.target    = TARGET_CIRAM;
          res.ciram_a10 = state.hmirror ? ppu_addr[11] : ppu_addr[10];
        end else if (!ppu_addr[12]) begin
          res.target   = TARGET_CHR;
          res.rom_addr = {3'd0, chr2k[7:1], ppu_addr[10:0]};
        end else begin
          res.target   = TARGET_CHR;
          res.rom_addr = {3'd0, chr1k, ppu_addr[9:0]};
        end
      end
      default: ;
    endcase
  end

endmodule
